### rtl/core/event_frame_decay_store_defines.svh
// Assertion macros for the frame store module.
`ifndef EVENT_FRAME_DECAY_STORE_DEFINES_SVH
`define EVENT_FRAME_DECAY_STORE_DEFINES_SVH

// Checked on every rising edge outside of reset.
`define EFDS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define EFDS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/core/efds_pkg.sv
package efds_pkg;

   localparam int COORD_W = 7;
   localparam int RGB_W   = 24;
   localparam int CH_W    = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [RGB_W-1:0] ON_COLOR_RESET  = 24'hFFFFFF;
   localparam logic [RGB_W-1:0] OFF_COLOR_RESET = 24'h000000;
   localparam logic [RGB_W-1:0] MID_COLOR_RESET = 24'h808080;
   localparam logic [CH_W-1:0]  DECAY_STEP_RESET = 8'd24;

   localparam logic REQ_EVENT = 1'b0;
   localparam logic REQ_DECAY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ON_COLOR   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_COLOR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_COLOR  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_STEP = 2'd3;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_RUN,
      ST_DECAY
   } state_type;

endpackage

### rtl/core/efds_pixel_mem.sv
module efds_pixel_mem #(
   parameter int DEPTH = 16384
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [efds_pkg::RGB_W-1:0]       wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [efds_pkg::RGB_W-1:0]       rd_data
);

   logic [efds_pkg::RGB_W-1:0] mem_ff [DEPTH];
   logic [efds_pkg::RGB_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/efds_decay.sv
module efds_decay (
   input  logic [efds_pkg::RGB_W-1:0] cur_rgb,
   input  logic [efds_pkg::RGB_W-1:0] mid_rgb,
   input  logic [efds_pkg::CH_W-1:0]  step,
   output logic [efds_pkg::RGB_W-1:0] new_rgb
);

   localparam int NCH = efds_pkg::RGB_W / efds_pkg::CH_W;

   // A channel moves by the step toward the target and stops on it.
   function automatic logic [efds_pkg::CH_W-1:0] step_channel(
      input logic [efds_pkg::CH_W-1:0] cur,
      input logic [efds_pkg::CH_W-1:0] tgt,
      input logic [efds_pkg::CH_W-1:0] dlt
   );
      logic [efds_pkg::CH_W:0] tgt_plus;
      logic [efds_pkg::CH_W:0] cur_plus;
      logic [efds_pkg::CH_W-1:0] res;
      tgt_plus = {1'b0, tgt} + {1'b0, dlt};
      cur_plus = {1'b0, cur} + {1'b0, dlt};
      if ({1'b0, cur} >= tgt_plus) begin
         res = cur - dlt;
      end else if (cur_plus <= {1'b0, tgt}) begin
         res = cur_plus[efds_pkg::CH_W-1:0];
      end else begin
         res = tgt;
      end
      return res;
   endfunction

   always_comb begin
      for (int i = 0; i < NCH; i++) begin
         new_rgb[i*efds_pkg::CH_W +: efds_pkg::CH_W] =
            step_channel(cur_rgb[i*efds_pkg::CH_W +: efds_pkg::CH_W],
                         mid_rgb[i*efds_pkg::CH_W +: efds_pkg::CH_W], step);
      end
   end

endmodule

### rtl/core/event_frame_decay_store.sv
// Timing: an event is written in the cycle of its transfer; a decay reads its pixel into the
// memory read register, then its result is loaded into the output register once that is free.
// Throughput: one event per cycle while no decay is pending; a decay holds off requests until
// its write-back, which waits behind the pixel memory read register and any output stall.
// Reset: registers return to their defaults, then a clearing pass writes mid gray into every
// pixel while input transfers are held off; register writes are taken.
`include "event_frame_decay_store_defines.svh"

module event_frame_decay_store #(
   parameter int SIDE = 128
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_type,
   input  logic [efds_pkg::COORD_W-1:0]           req_col,
   input  logic [efds_pkg::COORD_W-1:0]           req_row,
   input  logic                                   req_polarity,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [efds_pkg::RGB_W-1:0]             rsp_pixel_rgb,
   input  logic                                   csr_wr_en,
   input  logic [efds_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [efds_pkg::RGB_W-1:0]             csr_wdata
);

   localparam int DEPTH  = SIDE * SIDE;
   localparam int ADDR_W = $clog2(DEPTH);

   efds_pkg::state_type state_ff, state_in;

   logic [efds_pkg::RGB_W-1:0] on_color_ff, off_color_ff, mid_color_ff;
   logic [efds_pkg::CH_W-1:0]  decay_step_ff;

   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic [ADDR_W-1:0] dec_addr_ff, dec_addr_in;
   logic              dec_inside_ff, dec_inside_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [efds_pkg::RGB_W-1:0] rsp_rgb_ff, rsp_rgb_in;

   logic                       in_frame;
   logic [ADDR_W-1:0]          row_sel;
   logic [ADDR_W-1:0]          req_addr;
   logic                       req_xfer;
   logic                       decay_done;
   logic                       mem_wr_en;
   logic [ADDR_W-1:0]          mem_wr_addr;
   logic [efds_pkg::RGB_W-1:0] mem_wr_data;
   logic                       mem_rd_en;
   logic [efds_pkg::RGB_W-1:0] mem_rd_data;
   logic [efds_pkg::RGB_W-1:0] decayed_rgb;
   logic                       in_clear;
   logic                       in_wait;
   logic                       decay_xfer;

   assign in_frame = (int'(req_col) < SIDE) && (int'(req_row) < SIDE);
   assign row_sel = (req_type == efds_pkg::REQ_EVENT)
                  ? ADDR_W'(SIDE - 1) - ADDR_W'(req_row)
                  : ADDR_W'(req_row);
   assign req_addr = ADDR_W'(row_sel * ADDR_W'(SIDE)) + ADDR_W'(req_col);

   efds_pixel_mem #(
      .DEPTH(DEPTH)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(req_addr),
      .rd_data(mem_rd_data)
   );

   efds_decay u_decay (
      .cur_rgb(mem_rd_data),
      .mid_rgb(mid_color_ff),
      .step   (decay_step_ff),
      .new_rgb(decayed_rgb)
   );

   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      dec_addr_in   = dec_addr_ff;
      dec_inside_in = dec_inside_ff;
      req_stall     = 1'b1;
      req_xfer      = 1'b0;
      decay_done    = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = req_addr;
      mem_wr_data   = req_polarity ? on_color_ff : off_color_ff;
      mem_rd_en     = 1'b0;
      case (state_ff)
         efds_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_ff;
            mem_wr_data = efds_pkg::MID_COLOR_RESET;
            clr_cnt_in  = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = efds_pkg::ST_RUN;
            end
         end
         efds_pkg::ST_RUN: begin
            req_stall = 1'b0;
            req_xfer  = req_valid;
            if (req_xfer && req_type == efds_pkg::REQ_EVENT) begin
               mem_wr_en = in_frame;
            end
            if (req_xfer && req_type == efds_pkg::REQ_DECAY) begin
               mem_rd_en     = 1'b1;
               dec_addr_in   = req_addr;
               dec_inside_in = in_frame;
               state_in      = efds_pkg::ST_DECAY;
            end
         end
         efds_pkg::ST_DECAY: begin
            decay_done  = !rsp_valid_ff || !rsp_stall;
            mem_wr_en   = decay_done && dec_inside_ff;
            mem_wr_addr = dec_addr_ff;
            mem_wr_data = decayed_rgb;
            if (decay_done) begin
               state_in = efds_pkg::ST_RUN;
            end
         end
         default: begin
            state_in = efds_pkg::ST_RUN;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_rgb_in   = rsp_rgb_ff;
      if (decay_done) begin
         rsp_valid_in = 1'b1;
         rsp_rgb_in   = dec_inside_ff ? decayed_rgb : '0;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= efds_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dec_addr_ff   <= dec_addr_in;
      dec_inside_ff <= dec_inside_in;
      rsp_rgb_ff    <= rsp_rgb_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_color_ff   <= efds_pkg::ON_COLOR_RESET;
         off_color_ff  <= efds_pkg::OFF_COLOR_RESET;
         mid_color_ff  <= efds_pkg::MID_COLOR_RESET;
         decay_step_ff <= efds_pkg::DECAY_STEP_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            efds_pkg::CSR_ON_COLOR:   on_color_ff   <= csr_wdata;
            efds_pkg::CSR_OFF_COLOR:  off_color_ff  <= csr_wdata;
            efds_pkg::CSR_MID_COLOR:  mid_color_ff  <= csr_wdata;
            efds_pkg::CSR_DECAY_STEP: decay_step_ff <= csr_wdata[efds_pkg::CH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_rgb = rsp_rgb_ff;

   assign in_clear   = (state_ff == efds_pkg::ST_CLEAR);
   assign in_wait    = (state_ff == efds_pkg::ST_DECAY);
   assign decay_xfer = req_xfer && (req_type == efds_pkg::REQ_DECAY);

   `EFDS_ASSERT(a_no_rsp_in_clear, in_clear |-> !rsp_valid_ff, "result during clearing pass")
   `EFDS_ASSERT(a_decay_enters_wait, decay_xfer |=> in_wait, "decay transfer did not wait")
   `EFDS_ASSERT(a_decay_loads_rsp, decay_done |=> rsp_valid_ff, "finished decay left no result")
   `EFDS_ASSERT(a_wait_write_at_done, (in_wait && mem_wr_en) |-> decay_done, "early pixel write")
   `EFDS_ASSERT_ALWAYS(a_reset_clears, reset |=> in_clear && !rsp_valid_ff, "reset missed clear")

endmodule
